FILE: design/scm_pkg.sv
package scm_pkg;

    localparam int KEY_W     = 16;
    localparam int ROW_IDX_W = 3;
    localparam int SETTLE_W  = 8;
    localparam int PIN_W     = 5;

    typedef enum logic [4:0] {
        PH_INIT_CLK_LO, PH_INIT_CLK_HI, PH_INIT_LAT_LO, PH_INIT_LAT_HI, PH_IDLE,
        PH_Z_CLK_LO, PH_Z_CLK_HI, PH_ONE_DLO, PH_ONE_DHI, PH_ONE_CLK_HI,
        PH_LAT_LO, PH_LAT_HI, PH_LOAD_HI, PH_LOAD_LO, PH_COL_LO, PH_COL_HI,
        PH_RCLK_LO, PH_RCLK_HI, PH_RLAT_LO, PH_RLAT_HI
    } t_phase;

    typedef struct packed {
        logic                 row_latch_pin;
        logic                 row_clock_pin;
        logic                 row_data_pin;
        logic                 col_load_pin;
        logic                 col_clock_pin;
        logic                 row_valid;
        logic [ROW_IDX_W-1:0] row_index;
        logic [KEY_W-1:0]     row_bits;
        logic                 row_changed;
        logic                 scan_done;
        logic                 scan_changed;
        logic                 busy_res;
    } t_res;

    // bit0 row latch, bit1 row clock, bit2 row data, bit3 col load, bit4 col clock
    function automatic logic [PIN_W-1:0] pins_of(input t_phase ph);
        logic [PIN_W-1:0] p;
        p = 5'b01000;
        if (ph == PH_INIT_LAT_HI || ph == PH_LAT_HI || ph == PH_RLAT_HI) begin
            p[0] = 1'b1;
        end
        if (ph == PH_INIT_CLK_HI || ph == PH_Z_CLK_HI || ph == PH_ONE_CLK_HI ||
            ph == PH_RCLK_HI) begin
            p[1] = 1'b1;
        end
        if (ph == PH_ONE_DHI || ph == PH_ONE_CLK_HI) begin
            p[2] = 1'b1;
        end
        if (ph == PH_LOAD_LO) begin
            p[3] = 1'b0;
        end
        if (ph == PH_COL_HI) begin
            p[4] = 1'b1;
        end
        return p;
    endfunction

endpackage

FILE: design/scm_req_if.sv
interface scm_req_if;
    logic valid;
    logic ready;
    logic col_data;
    logic start_scan;

    modport source (output valid, output col_data, output start_scan, input ready);
    modport sink   (input valid, input col_data, input start_scan, output ready);
endinterface

FILE: design/scm_res_if.sv
interface scm_res_if;
    logic        valid;
    logic        ready;
    logic        row_latch_pin;
    logic        row_clock_pin;
    logic        row_data_pin;
    logic        col_load_pin;
    logic        col_clock_pin;
    logic        row_valid;
    logic [2:0]  row_index;
    logic [15:0] row_bits;
    logic        row_changed;
    logic        scan_done;
    logic        scan_changed;
    logic        busy_res;

    modport source (
        output valid, output row_latch_pin, output row_clock_pin, output row_data_pin,
        output col_load_pin, output col_clock_pin, output row_valid, output row_index,
        output row_bits, output row_changed, output scan_done, output scan_changed,
        output busy_res, input ready
    );
    modport sink (
        input valid, input row_latch_pin, input row_clock_pin, input row_data_pin,
        input col_load_pin, input col_clock_pin, input row_valid, input row_index,
        input row_bits, input row_changed, input scan_done, input scan_changed,
        input busy_res, output ready
    );
endinterface

FILE: design/scm_keys.sv
module scm_keys
    import scm_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int IW   = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IW-1:0]    i_addr,
    input  logic             i_we,
    input  logic [KEY_W-1:0] i_wdata,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_keys [ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_keys[i] <= '0;
            end
        end else if (i_we) begin
            r_keys[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_keys[i_addr];

endmodule

FILE: design/scm_seq.sv
module scm_seq
    import scm_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SETTLE_W-1:0] i_cfg_data,
    input  logic                i_accept,
    input  logic                i_col_data,
    input  logic                i_start_scan,
    output t_res                o_res
);

    localparam int RW = $clog2(ROWS + 1);
    localparam int CW = $clog2(COLS + 1);
    localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW = $clog2(KEY_W);

    logic [SETTLE_W-1:0] r_settle;
    t_phase              r_phase,   n_phase;
    logic [RW-1:0]       r_row_cnt, n_row_cnt;
    logic [CW-1:0]       r_col_cnt, n_col_cnt;
    logic [SETTLE_W-1:0] r_wait,    n_wait;
    logic [KEY_W-1:0]    r_accum,   n_accum;
    logic                r_any,     n_any;

    logic [IW-1:0]       key_addr;
    logic                key_we;
    logic [KEY_W-1:0]    key_rdata;

    scm_keys #(.ROWS(ROWS), .IW(IW)) u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (key_addr),
        .i_we    (key_we),
        .i_wdata (r_accum),
        .o_rdata (key_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_W'(1);
        end else if (i_cfg_we) begin
            r_settle <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_INIT_CLK_LO;
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_wait    <= '0;
            r_accum   <= '0;
            r_any     <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
            r_wait    <= n_wait;
            r_accum   <= n_accum;
            r_any     <= n_any;
        end
    end

    always_comb begin
        logic [SETTLE_W-1:0] limit;
        logic [SETTLE_W-1:0] wait_inc;
        logic [PIN_W-1:0]    pins;
        logic                started;
        t_phase              ph;

        limit   = (r_settle == '0) ? SETTLE_W'(1) : r_settle;
        started = (r_phase == PH_IDLE) && i_start_scan;
        ph      = started ? ((ROWS > 1) ? PH_Z_CLK_LO : PH_ONE_DLO) : r_phase;

        n_phase   = ph;
        n_row_cnt = started ? '0 : r_row_cnt;
        n_col_cnt = r_col_cnt;
        n_wait    = started ? '0 : r_wait;
        n_accum   = r_accum;
        n_any     = started ? 1'b0 : r_any;

        key_addr = (r_row_cnt < RW'(ROWS)) ? IW'(r_row_cnt) : IW'(ROWS - 1);
        key_we   = 1'b0;

        pins = pins_of(ph);
        o_res               = '0;
        o_res.row_latch_pin = pins[0];
        o_res.row_clock_pin = pins[1];
        o_res.row_data_pin  = pins[2];
        o_res.col_load_pin  = pins[3];
        o_res.col_clock_pin = pins[4];
        o_res.busy_res      = (ph != PH_IDLE);

        wait_inc = n_wait + SETTLE_W'(1);
        if (ph != PH_IDLE) begin
            n_wait = wait_inc;
            if (wait_inc >= limit) begin
                n_wait = '0;
                case (ph)
                    PH_INIT_CLK_HI: begin
                        n_row_cnt = n_row_cnt + RW'(1);
                        if (n_row_cnt >= RW'(ROWS)) begin
                            n_row_cnt = '0;
                            n_phase   = PH_INIT_LAT_LO;
                        end else begin
                            n_phase = PH_INIT_CLK_LO;
                        end
                    end
                    PH_INIT_LAT_HI: begin
                        n_phase = PH_IDLE;
                    end
                    PH_Z_CLK_HI: begin
                        n_row_cnt = n_row_cnt + RW'(1);
                        n_phase   = (n_row_cnt >= RW'(ROWS - 1)) ? PH_ONE_DLO : PH_Z_CLK_LO;
                    end
                    PH_LAT_HI: begin
                        n_row_cnt = '0;
                        n_accum   = '0;
                        n_phase   = PH_LOAD_HI;
                    end
                    PH_LOAD_LO: begin
                        n_col_cnt = '0;
                        n_phase   = PH_COL_LO;
                    end
                    PH_COL_LO: begin
                        if (i_col_data && (32'(r_col_cnt) < KEY_W)) begin
                            n_accum[AW'(r_col_cnt)] = 1'b1;
                        end
                        n_phase = PH_COL_HI;
                    end
                    PH_COL_HI: begin
                        n_col_cnt = r_col_cnt + CW'(1);
                        n_phase   = (n_col_cnt >= CW'(COLS)) ? PH_RCLK_LO : PH_COL_LO;
                    end
                    PH_RLAT_HI: begin
                        o_res.row_valid = 1'b1;
                        o_res.row_index = ROW_IDX_W'(key_addr);
                        o_res.row_bits  = r_accum;
                        if (key_rdata != r_accum) begin
                            o_res.row_changed = 1'b1;
                            n_any             = 1'b1;
                            key_we            = 1'b1;
                        end
                        n_row_cnt = n_row_cnt + RW'(1);
                        n_accum   = '0;
                        if (n_row_cnt >= RW'(ROWS)) begin
                            o_res.scan_done    = 1'b1;
                            o_res.scan_changed = n_any;
                            n_row_cnt          = '0;
                            n_phase            = PH_IDLE;
                        end else begin
                            n_phase = PH_LOAD_HI;
                        end
                    end
                    default: begin
                        n_phase = t_phase'(ph + 5'd1);
                    end
                endcase
            end
        end

        key_we = key_we && i_accept;
    end

endmodule

FILE: design/shift_register_key_matrix_scanner.sv
// channel | dir | handshake         | payload
// i_req   | in  | valid/ready       | col_data, start_scan
// o_res   | out | valid/ready       | pin levels, row report, scan report, busy_res
// cfg     | in  | i_cfg_we          | i_cfg_data = settle_ticks
//
// One request per clock while ready; each yields one result in the next cycle.
// The sequencer state and key store advance in the accepting cycle; the result
// waits in the output register, and i_req.ready stays high while it is taken.
// Reset is synchronous and starts the row driver clear sequence.
module shift_register_key_matrix_scanner
    import scm_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SETTLE_W-1:0] i_cfg_data,
    scm_req_if.sink             i_req,
    scm_res_if.source           o_res
);

    logic accept;
    t_res seq_res;
    t_res r_res;
    logic r_valid;

    assign i_req.ready = !r_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    scm_seq #(.ROWS(ROWS), .COLS(COLS)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_col_data   (i_req.col_data),
        .i_start_scan (i_req.start_scan),
        .o_res        (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= seq_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.row_latch_pin = r_res.row_latch_pin;
    assign o_res.row_clock_pin = r_res.row_clock_pin;
    assign o_res.row_data_pin  = r_res.row_data_pin;
    assign o_res.col_load_pin  = r_res.col_load_pin;
    assign o_res.col_clock_pin = r_res.col_clock_pin;
    assign o_res.row_valid     = r_res.row_valid;
    assign o_res.row_index     = r_res.row_index;
    assign o_res.row_bits      = r_res.row_bits;
    assign o_res.row_changed   = r_res.row_changed;
    assign o_res.scan_done     = r_res.scan_done;
    assign o_res.scan_changed  = r_res.scan_changed;
    assign o_res.busy_res      = r_res.busy_res;

endmodule
